/* hdl/rect80_pkg.sv */
// Shared types, constants and round functions for the RECTANGLE-80 encryption block.
// Used by the round cells, the output stage and the top level; depends on nothing else.

package rect80_pkg;

  // Number of cipher rounds; the round key after the last round whitens the output.
  localparam int ROUNDS = 25;

  localparam int BLOCK_W = 64;
  localparam int ROW_W   = 16;
  localparam int KEY_W   = 80;
  localparam int RC_W    = 5;
  localparam int RC_IDX_W = 5;

  // Configuration register indexes.
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // Forward link between neighboring cells: a block in flight and the key state.
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] data;
    logic [KEY_W-1:0]   key;
  } link_t;

  // Four-bit S-box.
  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h6;
      4'h1: y = 4'h5;
      4'h2: y = 4'hc;
      4'h3: y = 4'ha;
      4'h4: y = 4'h1;
      4'h5: y = 4'he;
      4'h6: y = 4'h7;
      4'h7: y = 4'h9;
      4'h8: y = 4'hb;
      4'h9: y = 4'h0;
      4'ha: y = 4'h3;
      4'hb: y = 4'hd;
      4'hc: y = 4'h8;
      4'hd: y = 4'hf;
      4'he: y = 4'h4;
      4'hf: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // Round constants of the key schedule, one per key step.
  function automatic logic [RC_W-1:0] rc_table(input logic [RC_IDX_W-1:0] idx);
    logic [RC_W-1:0] rc;
    case (idx)
      5'd0:  rc = 5'h01;
      5'd1:  rc = 5'h02;
      5'd2:  rc = 5'h04;
      5'd3:  rc = 5'h09;
      5'd4:  rc = 5'h12;
      5'd5:  rc = 5'h05;
      5'd6:  rc = 5'h0b;
      5'd7:  rc = 5'h16;
      5'd8:  rc = 5'h0c;
      5'd9:  rc = 5'h19;
      5'd10: rc = 5'h13;
      5'd11: rc = 5'h07;
      5'd12: rc = 5'h0f;
      5'd13: rc = 5'h1f;
      5'd14: rc = 5'h1e;
      5'd15: rc = 5'h1c;
      5'd16: rc = 5'h18;
      5'd17: rc = 5'h11;
      5'd18: rc = 5'h03;
      5'd19: rc = 5'h06;
      5'd20: rc = 5'h0d;
      5'd21: rc = 5'h1b;
      5'd22: rc = 5'h17;
      5'd23: rc = 5'h0e;
      5'd24: rc = 5'h1d;
      default: rc = 5'h00;
    endcase
    return rc;
  endfunction

  // One cipher round after the key XOR: S-box on all columns, then row rotations.
  function automatic logic [BLOCK_W-1:0] round_fn(input logic [BLOCK_W-1:0] s);
    logic [ROW_W-1:0] r0, r1, r2, r3;
    logic [3:0]       col;
    r0 = s[15:0];
    r1 = s[31:16];
    r2 = s[47:32];
    r3 = s[63:48];
    for (int j = 0; j < ROW_W; j++) begin
      col = sbox({s[48+j], s[32+j], s[16+j], s[j]});
      r0[j] = col[0];
      r1[j] = col[1];
      r2[j] = col[2];
      r3[j] = col[3];
    end
    return {{r3[2:0], r3[15:3]}, {r2[3:0], r2[15:4]}, {r1[14:0], r1[15]}, r0};
  endfunction

  // One step of the 80-bit key schedule.
  function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] k,
                                                input logic [RC_W-1:0] rc);
    logic [ROW_W-1:0] k0, k1, k2, k3, k4;
    logic [3:0]       col;
    k0 = k[15:0];
    k1 = k[31:16];
    k2 = k[47:32];
    k3 = k[63:48];
    k4 = k[79:64];
    // Only the four rightmost columns pass through the S-box.
    for (int j = 0; j < 4; j++) begin
      col = sbox({k3[j], k2[j], k1[j], k0[j]});
      k0[j] = col[0];
      k1[j] = col[1];
      k2[j] = col[2];
      k3[j] = col[3];
    end
    return {k0,
            {k3[3:0], k3[15:4]} ^ k4,
            k3,
            k2,
            {k0[7:0], k0[15:8]} ^ k1 ^ {{(ROW_W-RC_W){1'b0}}, rc}};
  endfunction

  // Final key XOR and reversal of the four 16-bit words.
  function automatic logic [BLOCK_W-1:0] finish_fn(input logic [BLOCK_W-1:0] s,
                                                   input logic [BLOCK_W-1:0] rk);
    logic [BLOCK_W-1:0] t;
    t = s ^ rk;
    return {t[15:0], t[31:16], t[47:32], t[63:48]};
  endfunction

endpackage

/* hdl/rect80_round_cell.sv */
// One round cell: registers one cipher round of the block and one key schedule step.
// Depends on rect80_pkg.

module rect80_round_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  rect80_pkg::link_t            up,
  output logic                         up_ready,
  input  logic [rect80_pkg::RC_W-1:0]  rc,
  output rect80_pkg::link_t            dn,
  input  logic                         dn_ready
);
  import rect80_pkg::*;

  logic               valid;
  logic [BLOCK_W-1:0] state;
  logic [KEY_W-1:0]   key_state;

  // The cell takes a new block when it is empty or its content moves on.
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up.valid;
    end
  end

  // Round data: key XOR, S-box layer and row rotations.
  always_ff @(posedge clk) begin
    if (up_ready && up.valid) begin
      state <= round_fn(up.data ^ up.key[BLOCK_W-1:0]);
    end
  end

  // The key state moves down the chain every cycle and settles after a key write.
  always_ff @(posedge clk) begin
    key_state <= key_step(up.key, rc);
  end

  assign dn = '{valid: valid, data: state, key: key_state};

endmodule

/* hdl/rect80_out_stage.sv */
// Output stage: final whitening key, word reversal and the result register.
// Depends on rect80_pkg.

module rect80_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  rect80_pkg::link_t               up,
  output logic                            up_ready,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rect80_pkg::BLOCK_W-1:0]  m_axis_tdata
);
  import rect80_pkg::*;

  // The result register frees when empty or when the current result transfers.
  assign up_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (up_ready) begin
      m_axis_tvalid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up.valid) begin
      m_axis_tdata <= finish_fn(up.data, up.key[BLOCK_W-1:0]);
    end
  end

endmodule

/* hdl/rectangle80_block_encrypt.sv */
// Top level of the RECTANGLE-80 encryption block: key registers, round cell chain, output.
// Depends on rect80_pkg, rect80_round_cell and rect80_out_stage.
//
// Usage:
//   Plaintext blocks enter on the s_axis channel, ciphertext leaves on m_axis; one
//   64-bit block per transfer. The key is written through cfg_wr_en / cfg_index /
//   cfg_data: index 0 holds key rows 0 to 3, index 1 holds key row 4 in bits 15:0.
//   Each round cell computes one cipher round and one key schedule step, so after a
//   key write the round keys settle one cell per cycle while the block is idle.
//   From an input transfer to the result valid, a block passes one register per round
//   cell and then the output register.
//   Throughput is one block per cycle while m_axis_tready is high: every cell holds
//   its own round key, so a new block can enter each cycle.
//   When the receiver stalls, a cell holds its block only while the cell after it is
//   full; empty cells keep accepting, so the chain fills up before s_axis_tready drops.
//   Reset clears the key to zero, empties the chain and drops m_axis_tvalid; the
//   schedule of the zero key is ready as a block reaches each cell.

module rectangle80_block_encrypt (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [rect80_pkg::BLOCK_W-1:0]  cfg_data,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rect80_pkg::BLOCK_W-1:0]  s_axis_tdata,   // [63:0] plaintext
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rect80_pkg::BLOCK_W-1:0]  m_axis_tdata    // [63:0] ciphertext
);
  import rect80_pkg::*;

  logic [BLOCK_W-1:0] key_rows_low;
  logic [ROW_W-1:0]   key_row_four;
  link_t              link [0:ROUNDS];
  logic [ROUNDS:0]    ready;

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_rows_low <= '0;
      key_row_four <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_LOW:  key_rows_low <= cfg_data;
        REG_KEY_HIGH: key_row_four <= cfg_data[ROW_W-1:0];
        default:      key_rows_low <= key_rows_low;
      endcase
    end
  end

  // Head of the chain: the incoming block with the master key as key state.
  assign link[0] = '{valid: s_axis_tvalid, data: s_axis_tdata,
                     key: {key_row_four, key_rows_low}};
  assign s_axis_tready = ready[0] && !rst;

  // One cell per round.
  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    rect80_round_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up       (link[i]),
      .up_ready (ready[i]),
      .rc       (rc_table(RC_IDX_W'(i))),
      .dn       (link[i+1]),
      .dn_ready (ready[i+1])
    );
  end

  rect80_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .up            (link[ROUNDS]),
    .up_ready      (ready[ROUNDS]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // An input transfer always lands in the first cell.
  a_enter_first_cell: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> link[1].valid)
    else $error("accepted block did not enter the first round cell");

  // A finished block in the last cell waits while the output register is held.
  a_last_cell_holds: assert property (@(posedge clk) disable iff (rst)
    link[ROUNDS].valid && !ready[ROUNDS] |=> link[ROUNDS].valid)
    else $error("block in the last round cell was lost during a stall");

  // Nothing leaves the block in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule
